@@ design/bmrp_pkg.sv @@
// Shared types, request codes and the freshness check for the range pairing block.
`timescale 1ns / 1ps

package bmrp_pkg;

  localparam int unsigned RING_DEPTH_DEF = 8;
  localparam logic [31:0] STALE_DEFAULT_MS = 32'd1500;

  localparam logic [1:0] REQ_OWN   = 2'd0;
  localparam logic [1:0] REQ_PEER  = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  localparam int unsigned CFG_AW = 3;
  localparam logic CFG_IDX_STALE = 1'b0;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] distance_mm;
    logic [31:0] round_block;
    logic [63:0] now_time_ms;
  } item_t;

  typedef struct packed {
    logic        pair_valid;
    logic [30:0] own_distance_mm;
    logic [30:0] peer_distance_mm;
    logic [31:0] pair_block;
  } result_t;

  // Age = now - stamp, exact in 65 bits; a stamp in the future is stale.
  function automatic logic is_fresh(logic [63:0] now, logic [63:0] stamp,
                                    logic [31:0] limit);
    logic [64:0] age;
    age = {now[63], now} - {stamp[63], stamp};
    return !age[64] && (age[63:0] <= {32'd0, limit});
  endfunction

endpackage

@@ design/bmrp_ring.sv @@
// Own-measurement ring, peer report store and the block-matched pair lookup.
`timescale 1ns / 1ps

module bmrp_ring
  import bmrp_pkg::*;
#(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        upd_i,
  input  item_t       item_i,
  input  logic [31:0] limit_i,
  output result_t     res_o
);

  localparam int unsigned SW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  logic [RING_DEPTH-1:0] ent_valid_r;
  logic [31:0]           ent_block_r [RING_DEPTH];
  logic [30:0]           ent_dist_r  [RING_DEPTH];
  logic [63:0]           ent_stamp_r [RING_DEPTH];
  logic [SW-1:0]         slot_r;
  logic [SW-1:0]         slot_nxt;

  logic        peer_present_r;
  logic [30:0] peer_dist_r;
  logic [31:0] peer_round_r;
  logic [63:0] peer_stamp_r;

  logic wr_own;
  logic wr_peer;

  // view of the stores with this request's own write already applied
  logic [RING_DEPTH-1:0] eff_valid;
  logic [31:0]           eff_block [RING_DEPTH];
  logic [30:0]           eff_dist  [RING_DEPTH];
  logic [63:0]           eff_stamp [RING_DEPTH];
  logic                  eff_peer_present;
  logic [30:0]           eff_peer_dist;
  logic [31:0]           eff_peer_round;
  logic [63:0]           eff_peer_stamp;

  logic        hit;
  logic        own_fresh;
  logic [30:0] own_dist;
  logic        peer_fresh;

  assign wr_own  = (item_i.req_type == REQ_OWN)  && !item_i.distance_mm[31];
  assign wr_peer = (item_i.req_type == REQ_PEER) && !item_i.distance_mm[31];

  assign slot_nxt = (slot_r == SW'(RING_DEPTH - 1)) ? '0 : slot_r + SW'(1);

  always_comb begin
    for (int i = 0; i < RING_DEPTH; i++) begin
      if (wr_own && (slot_r == SW'(i))) begin
        eff_valid[i] = 1'b1;
        eff_block[i] = item_i.round_block;
        eff_dist[i]  = item_i.distance_mm[30:0];
        eff_stamp[i] = item_i.now_time_ms;
      end else begin
        eff_valid[i] = ent_valid_r[i];
        eff_block[i] = ent_block_r[i];
        eff_dist[i]  = ent_dist_r[i];
        eff_stamp[i] = ent_stamp_r[i];
      end
    end
  end

  assign eff_peer_present = peer_present_r | wr_peer;
  assign eff_peer_dist    = wr_peer ? item_i.distance_mm[30:0] : peer_dist_r;
  assign eff_peer_round   = wr_peer ? item_i.round_block : peer_round_r;
  assign eff_peer_stamp   = wr_peer ? item_i.now_time_ms : peer_stamp_r;

  // first valid entry of the peer's block decides, fresh or not
  always_comb begin
    hit       = 1'b0;
    own_fresh = 1'b0;
    own_dist  = '0;
    for (int i = 0; i < RING_DEPTH; i++) begin
      if (!hit && eff_valid[i] && (eff_block[i] == eff_peer_round)) begin
        hit       = 1'b1;
        own_fresh = is_fresh(item_i.now_time_ms, eff_stamp[i], limit_i);
        own_dist  = eff_dist[i];
      end
    end
  end

  assign peer_fresh = eff_peer_present &&
                      is_fresh(item_i.now_time_ms, eff_peer_stamp, limit_i);

  always_comb begin
    res_o = '0;
    if (peer_fresh && hit && own_fresh) begin
      res_o.pair_valid       = 1'b1;
      res_o.own_distance_mm  = own_dist;
      res_o.peer_distance_mm = eff_peer_dist;
      res_o.pair_block       = eff_peer_round;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_valid_r    <= '0;
      slot_r         <= '0;
      peer_present_r <= 1'b0;
    end else if (upd_i) begin
      if (wr_own) begin
        ent_valid_r[slot_r] <= 1'b1;
        slot_r              <= slot_nxt;
      end
      if (wr_peer) begin
        peer_present_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd_i && wr_own) begin
      ent_block_r[slot_r] <= item_i.round_block;
      ent_dist_r[slot_r]  <= item_i.distance_mm[30:0];
      ent_stamp_r[slot_r] <= item_i.now_time_ms;
    end
    if (upd_i && wr_peer) begin
      peer_dist_r  <= item_i.distance_mm[30:0];
      peer_round_r <= item_i.round_block;
      peer_stamp_r <= item_i.now_time_ms;
    end
  end

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (slot_r == '0) && !peer_present_r && (ent_valid_r == '0))
    else $error("stores not cleared after reset");

  a_own_written: assert property (@(posedge clk) disable iff (!rst_n)
    (upd_i && wr_own) |=> ent_valid_r[$past(slot_r)] &&
      (ent_block_r[$past(slot_r)] == $past(item_i.round_block)))
    else $error("own measurement not held in its ring slot");

  a_peer_written: assert property (@(posedge clk) disable iff (!rst_n)
    (upd_i && wr_peer) |=> peer_present_r &&
      (peer_round_r == $past(item_i.round_block)))
    else $error("peer report not stored");

  a_pair_needs_peer: assert property (@(posedge clk) disable iff (!rst_n)
    res_o.pair_valid |-> eff_peer_present && hit)
    else $error("pair reported without peer report and matching entry");

endmodule

@@ design/block_matched_range_pairing.sv @@
// Top level: pairs own range measurements with a peer report of the same block.
`timescale 1ns / 1ps

// Channel   Direction  Contents
// in_       slave      request: tuser = req_type, tdata = distance, block, time
// out_      master     one result per request: tuser = pair_valid, tdata = values
// cfg_      APB slave  stale_limit_ms at byte address 0
//
// One request per cycle sustained while out_ is ready; each result passes the
// input register, then the result register.
// The lookup, store update and both age checks sit in the logic between the
// two registers; back-pressure on out_ holds the request in the input register
// and its store update waits with it, so later requests see earlier writes.
// Synchronous active-low reset empties the ring and peer store at once (valid
// flags only) and sets the stale limit to 1500 ms.

module block_matched_range_pairing
  import bmrp_pkg::*;
#(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // slave side
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [127:0]      in_tdata,   // [31:0] distance_mm, [63:32] round_block,
                                        // [127:64] now_time_ms
  input  logic [1:0]        in_tuser,   // [1:0] req_type
  // master side
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [95:0]       out_tdata,  // [30:0] own_distance_mm,
                                        // [61:31] peer_distance_mm,
                                        // [93:62] pair_block, [95:94] zero
  output logic [0:0]        out_tuser,  // [0] pair_valid
  // configuration
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  logic        s1_valid_r;
  item_t       s1_item_r;
  logic        out_valid_r;
  result_t     out_res_r;
  logic        adv;
  result_t     res;

  logic [31:0] stale_r;
  logic [31:0] limit;
  logic        cfg_wr;

  // ---- configuration ----
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == CFG_IDX_STALE) ? stale_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stale_r <= STALE_DEFAULT_MS;
    end else if (cfg_wr && (cfg_paddr[2] == CFG_IDX_STALE)) begin
      stale_r <= cfg_pwdata;
    end
  end

  // zero selects the default limit
  assign limit = (stale_r == 32'd0) ? STALE_DEFAULT_MS : stale_r;

  // ---- request path ----
  // the held request moves on whenever the result register is free or draining
  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_item_r.req_type    <= in_tuser;
      s1_item_r.distance_mm <= in_tdata[31:0];
      s1_item_r.round_block <= in_tdata[63:32];
      s1_item_r.now_time_ms <= in_tdata[127:64];
    end
  end

  bmrp_ring #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .upd_i   (adv),
    .item_i  (s1_item_r),
    .limit_i (limit),
    .res_o   (res)
  );

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.pair_valid;
  assign out_tdata  = {2'b00, out_res_r.pair_block, out_res_r.peer_distance_mm,
                       out_res_r.own_distance_mm};

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the block-matched range pairing block.
`timescale 1ns / 1ps

module testbench;
  import bmrp_pkg::*;

  localparam int unsigned RING = RING_DEPTH_DEF;
  // unused request code: behaves as a query
  localparam logic [1:0] REQ_SPARE = 2'd3;
  localparam logic [CFG_AW-1:0] STALE_ADDR = {CFG_IDX_STALE, 2'b00};
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_PER_PHASE = 62;
  localparam int NUM_PHASES = 7;
  localparam result_t NO_PAIR = '0;

  // one row of the directed table: request plus optional typed-in result
  typedef struct packed {
    item_t   req;
    logic    typed;
    result_t res;
  } dir_row_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [95:0]  out_tdata;
  logic [0:0]   out_tuser;
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  block_matched_range_pairing dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),    // [31:0] distance, [63:32] block, [127:64] time
    .in_tuser    (in_tuser),    // [1:0] req_type
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),   // [30:0] own, [61:31] peer, [93:62] block
    .out_tuser   (out_tuser),   // [0] pair_valid
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the block: own-measurement ring, peer report, stale limit
  // ---------------------------------------------------------------------------
  bit          ring_used  [RING];
  logic [31:0] ring_blk   [RING];
  logic [30:0] ring_dist  [RING];
  logic [63:0] ring_stamp [RING];
  int unsigned ring_wr;
  bit          peer_have;
  logic [30:0] peer_dist_m;
  logic [31:0] peer_blk_m;
  logic [63:0] peer_stamp_m;
  logic [31:0] stale_lim_m;

  result_t pending_pairs [$];   // expected results, oldest first
  dir_row_t dir_rows [$];
  logic [31:0] phase_limits [NUM_PHASES];

  int requests_sent;
  int results_seen;
  int pairs_seen;
  int mismatches;
  int burst_left;
  int rdy_hold;
  int rdy_pick;
  logic [63:0] clock_ms;        // running time base for the random requests
  logic [31:0] blk_base;        // block numbers of a phase cluster round this
  result_t seen_pair;
  result_t want_pair;

  function automatic logic [63:0] limit_now();
    return (stale_lim_m == 32'd0) ? {32'd0, STALE_DEFAULT_MS} : {32'd0, stale_lim_m};
  endfunction

  // Fresh: stamp not ahead of now (signed) and the exact age within the limit.
  // With now >= stamp the true age fits in 64 unsigned bits.
  function automatic bit fresh_at(logic [63:0] now, logic [63:0] stamp);
    if ($signed(now) < $signed(stamp)) return 1'b0;
    return (now - stamp) <= limit_now();
  endfunction

  // Updates the shadow stores for one request and returns the pair it yields.
  function automatic result_t predict_pair(item_t it);
    result_t r;
    bit found;
    r = '0;
    found = 1'b0;
    if (!it.distance_mm[31]) begin
      if (it.req_type == REQ_OWN) begin
        ring_used[ring_wr]  = 1'b1;
        ring_blk[ring_wr]   = it.round_block;
        ring_dist[ring_wr]  = it.distance_mm[30:0];
        ring_stamp[ring_wr] = it.now_time_ms;
        ring_wr = (ring_wr + 1) % RING;
      end else if (it.req_type == REQ_PEER) begin
        peer_have    = 1'b1;
        peer_dist_m  = it.distance_mm[30:0];
        peer_blk_m   = it.round_block;
        peer_stamp_m = it.now_time_ms;
      end
    end
    if (peer_have && fresh_at(it.now_time_ms, peer_stamp_m)) begin
      // only the lowest matching entry counts, stale or not
      for (int k = 0; k < RING; k++) begin
        if (!found && ring_used[k] && ring_blk[k] == peer_blk_m) begin
          found = 1'b1;
          if (fresh_at(it.now_time_ms, ring_stamp[k])) begin
            r.pair_valid       = 1'b1;
            r.own_distance_mm  = ring_dist[k];
            r.peer_distance_mm = peer_dist_m;
            r.pair_block       = peer_blk_m;
          end
        end
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, mostly short stalls, some long ones,
  // and stretches where the sink never stalls.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rdy_hold > 0) begin
      rdy_hold <= rdy_hold - 1;
    end else begin
      rdy_pick = $urandom_range(0, 99);
      if (rdy_pick < 55) begin
        out_tready <= 1'b1;
        rdy_hold <= $urandom_range(0, 6);
      end else if (rdy_pick < 88) begin
        out_tready <= 1'b0;
        rdy_hold <= $urandom_range(0, 3);
      end else if (rdy_pick < 95) begin
        out_tready <= 1'b0;
        rdy_hold <= $urandom_range(8, 40);
      end else begin
        out_tready <= 1'b1;
        rdy_hold <= $urandom_range(20, 80);
      end
    end
  end

  task automatic note_mismatch(input string what, input result_t want,
                               input result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"[%0t] %s: expected v=%0d own=%0d peer=%0d blk=%h, ",
                "got v=%0d own=%0d peer=%0d blk=%h"},
               $time, what, want.pair_valid, want.own_distance_mm, want.peer_distance_mm,
               want.pair_block, got.pair_valid, got.own_distance_mm, got.peer_distance_mm,
               got.pair_block);
  endtask

  // Result monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_pair = {out_tuser[0], out_tdata[30:0], out_tdata[61:31], out_tdata[93:62]};
      results_seen++;
      if (seen_pair.pair_valid) pairs_seen++;
      if (pending_pairs.size() == 0) begin
        note_mismatch("result with nothing pending", NO_PAIR, seen_pair);
      end else begin
        want_pair = pending_pairs.pop_front();
        if (seen_pair.pair_valid !== want_pair.pair_valid ||
            seen_pair.own_distance_mm !== want_pair.own_distance_mm ||
            seen_pair.peer_distance_mm !== want_pair.peer_distance_mm ||
            seen_pair.pair_block !== want_pair.pair_block)
          note_mismatch("pair mismatch", want_pair, seen_pair);
      end
    end
  end

  // Watchdog: too many cycles in a row with no handshake on any port.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    wait (rst_n === 1'b1);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Timeout: no handshake for %0d cycles, %0d results pending",
             WATCHDOG_LIMIT, pending_pairs.size());
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Gap after a request: mostly none or short, a few long, and now and then
  // a burst of back-to-back requests.
  function automatic int gap_len();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(10, 30);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  // Presents one request, waits for it to be taken, then records the expected
  // pair (typed-in where given, else predicted). Returns on a rising edge;
  // valid stays high only when the next request follows straight away.
  task automatic push_request(input item_t it, input logic typed, input result_t typed_res);
    result_t p;
    int g;
    in_tvalid <= 1'b1;
    in_tuser  <= it.req_type;
    in_tdata  <= {it.now_time_ms, it.round_block, it.distance_mm};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    p = predict_pair(it);
    pending_pairs.push_back(typed ? typed_res : p);
    requests_sent++;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Hold off the sender until every expected result has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_pairs.size() != 0) @(posedge clk);
  endtask

  // APB write: setup, then access until pready; shadow follows at that edge.
  task automatic write_stale(input logic [31:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= STALE_ADDR;
    cfg_pwdata  <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    stale_lim_m = v;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic add_row(input logic [1:0] rq, input logic [31:0] d, input logic [31:0] b,
                         input logic [63:0] t, input logic ty, input result_t rs);
    dir_row_t row;
    row.req   = {rq, d, b, t};
    row.typed = ty;
    row.res   = rs;
    dir_rows.push_back(row);
  endtask

  // Random request. Time mostly creeps forward by a fraction of the limit,
  // sometimes jumps to or just over the limit or steps back (stamps in the future),
  // rarely lands anywhere in the 64-bit range. Blocks come from a small
  // cluster so that own and peer requests meet.
  function automatic item_t random_request();
    item_t it;
    int r;
    logic [63:0] span;
    logic [31:0] u;
    span = limit_now() / 3 + 1;
    if (span > 64'd1048576) span = 64'd1048576;
    r = $urandom_range(0, 99);
    if (r < 70)      clock_ms = clock_ms + $urandom_range(0, span[31:0]);
    else if (r < 80) clock_ms = clock_ms;
    else if (r < 90) clock_ms = clock_ms + limit_now() + $urandom_range(0, 1);
    else if (r < 95) clock_ms = clock_ms - $urandom_range(1, 3);
    else             clock_ms = {$urandom, $urandom};
    it.now_time_ms = clock_ms;
    it.round_block = blk_base + $urandom_range(0, 3);
    u = $urandom;
    it.distance_mm = {1'b0, u[30:0]};
    if ($urandom_range(0, 9) == 0) it.distance_mm = {1'b1, u[30:0]};
    r = $urandom_range(0, 99);
    if (r < 40)      it.req_type = REQ_OWN;
    else if (r < 70) it.req_type = REQ_PEER;
    else if (r < 85) it.req_type = REQ_QUERY;
    else if (r < 88) it.req_type = REQ_SPARE;
    else begin
      // noise: anything goes, time base left alone
      u = $urandom;
      it.req_type    = u[1:0];
      it.distance_mm = $urandom;
      it.round_block = $urandom;
      it.now_time_ms = {$urandom, $urandom};
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int k = 0; k < RING; k++) begin
      ring_used[k]  = 1'b0;
      ring_blk[k]   = '0;
      ring_dist[k]  = '0;
      ring_stamp[k] = '0;
    end
    ring_wr       = 0;
    peer_have     = 1'b0;
    peer_dist_m   = '0;
    peer_blk_m    = '0;
    peer_stamp_m  = '0;
    stale_lim_m   = STALE_DEFAULT_MS;
    requests_sent = 0;
    results_seen  = 0;
    pairs_seen    = 0;
    mismatches    = 0;
    burst_left    = 0;
    rdy_hold      = 0;
    clock_ms      = 64'd5000;

    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= '0;
    out_tready  <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, stale limit at its reset value of 1500 ms.
    // empty stores give no pair
    add_row(REQ_QUERY, 32'd0, 32'd0, 64'd0, 1'b1, NO_PAIR);
    // own entry at the distance and block extremes, no peer yet
    add_row(REQ_OWN, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 64'd1000, 1'b1, NO_PAIR);
    add_row(REQ_PEER, 32'd0, 32'hFFFF_FFFF, 64'd1000, 1'b1,
            {1'b1, 31'h7FFF_FFFF, 31'd0, 32'hFFFF_FFFF});
    // negative distance: store untouched, pair still returned
    add_row(REQ_PEER, 32'hFFFF_FFFF, 32'd5, 64'd1500, 1'b0, NO_PAIR);
    // unused code as query, age exactly at the limit is still fresh
    add_row(REQ_SPARE, 32'd0, 32'd0, 64'd2500, 1'b0, NO_PAIR);
    // one past the limit: peer stale
    add_row(REQ_QUERY, 32'd0, 32'd0, 64'd2501, 1'b1, NO_PAIR);
    add_row(REQ_OWN, 32'h8000_0000, 32'd7, 64'd2501, 1'b0, NO_PAIR);
    // fresh peer, but the only matching entry is stale
    add_row(REQ_PEER, 32'd1234, 32'hFFFF_FFFF, 64'd3000, 1'b0, NO_PAIR);
    // later fresh match does not help while the lowest match is stale
    add_row(REQ_OWN, 32'd42, 32'hFFFF_FFFF, 64'd3000, 1'b0, NO_PAIR);
    // peer stamp ahead of now
    add_row(REQ_QUERY, 32'd0, 32'd0, 64'd2999, 1'b0, NO_PAIR);
    // fill the ring, then wrap onto slot 0 with a fresh match
    for (int k = 0; k < 6; k++)
      add_row(REQ_OWN, 32'd10 + k, 32'd16 + k, 64'd3000, 1'b0, NO_PAIR);
    add_row(REQ_OWN, 32'd99, 32'hFFFF_FFFF, 64'd3001, 1'b0, NO_PAIR);
    // time extremes and age overflow
    add_row(REQ_PEER, 32'd1, 32'd0, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, NO_PAIR);
    add_row(REQ_OWN, 32'd2, 32'd0, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, NO_PAIR);
    add_row(REQ_QUERY, 32'd0, 32'd0, 64'h8000_0000_0000_0000, 1'b0, NO_PAIR);
    add_row(REQ_PEER, 32'd3, 32'd0, 64'h8000_0000_0000_0000, 1'b0, NO_PAIR);
    add_row(REQ_OWN, 32'd4, 32'd0, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, NO_PAIR);
    add_row(REQ_QUERY, 32'd0, 32'd0, 64'h8000_0000_0000_05DC, 1'b0, NO_PAIR);
    add_row(REQ_OWN, 32'd0, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, NO_PAIR);

    foreach (dir_rows[i])
      push_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);

    // Random phases, each under its own stale limit; written only when idle.
    phase_limits[0] = 32'd0;            // selects the 1500 ms default
    phase_limits[1] = 32'd1;
    phase_limits[2] = 32'd7;
    phase_limits[3] = 32'd250;
    phase_limits[4] = 32'hFFFF_FFFF;
    phase_limits[5] = $urandom_range(2, 100000);
    phase_limits[6] = STALE_DEFAULT_MS;
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      write_stale(phase_limits[p]);
      blk_base = $urandom;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        push_request(random_request(), 1'b0, NO_PAIR);
        if ($urandom_range(0, 49) == 0) drain();
      end
    end

    drain();
    repeat (10) @(posedge clk);

    $display("Ran %0d requests over %0d stale limit settings (default, 1 ms, full range)",
             requests_sent, NUM_PHASES + 1);
    $display("%0d results checked, %0d of them matched pairs, %0d mismatches",
             results_seen, pairs_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
